FILE: hdl/tpwc_pkg.sv
// ----------------------------------------------------------------------------
// tpwc_pkg
// Types and constants shared by the trend pattern window counter modules.
// ----------------------------------------------------------------------------
package tpwc_pkg;

    // trend codes, also the pattern entry codes
    typedef logic [1:0] t_trend;
    localparam t_trend TREND_EQUAL = 2'd0;
    localparam t_trend TREND_RISE  = 2'd1;
    localparam t_trend TREND_FALL  = 2'd2;
    localparam t_trend TREND_ANY   = 2'd3;

    localparam int SAMPLE_W     = 32;
    localparam int COUNT_W      = 32;
    localparam int LEN_REG_W    = 5;
    localparam int CODES_W      = 32;
    localparam int CODE_ENTRIES = CODES_W / 2;
    localparam int DATA_W       = 32;
    localparam int ADDR_W       = 3;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_LENGTH = 1'b0,
        REG_CODES  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       start_req;
    } t_in_beat;

    typedef struct packed {
        logic               window_match;
        logic [COUNT_W-1:0] match_count;
    } t_out_beat;

    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctrl;

endpackage

FILE: hdl/tpwc_regs.sv
// ----------------------------------------------------------------------------
// tpwc_regs
// APB-style register file: pattern length and packed pattern codes.
// ----------------------------------------------------------------------------
module tpwc_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tpwc_pkg::ADDR_W-1:0]      paddr,
    input  logic [tpwc_pkg::DATA_W-1:0]      pwdata,
    output logic [tpwc_pkg::DATA_W-1:0]      prdata,
    output logic                             pready,
    output logic [tpwc_pkg::LEN_REG_W-1:0]   o_pattern_length,
    output logic [tpwc_pkg::CODES_W-1:0]     o_pattern_codes
);
    import tpwc_pkg::*;

    logic [LEN_REG_W-1:0] r_len;
    logic [CODES_W-1:0]   r_codes;
    t_reg_idx             w_idx;
    logic                 w_wr;

    assign w_idx  = t_reg_idx'(paddr[2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= LEN_REG_W'(1);
            r_codes <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_LENGTH: r_len   <= pwdata[LEN_REG_W-1:0];
                REG_CODES:  r_codes <= pwdata[CODES_W-1:0];
                default:    r_len   <= r_len;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_LENGTH: prdata = DATA_W'(r_len);
            REG_CODES:  prdata = DATA_W'(r_codes);
            default:    prdata = '0;
        endcase
    end

    assign o_pattern_length = r_len;
    assign o_pattern_codes  = r_codes;

endmodule

FILE: hdl/tpwc_cell.sv
// ----------------------------------------------------------------------------
// tpwc_cell
// One history slot: holds a trend code, passes it on to the next slot and
// checks it against the pattern entry that lines up with it.
// ----------------------------------------------------------------------------
module tpwc_cell #(
    parameter int CELL_IDX = 0,
    parameter int LEN_W    = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tpwc_pkg::t_cell_ctrl          i_ctrl,
    input  tpwc_pkg::t_trend              i_code,
    output tpwc_pkg::t_trend              o_code,
    input  logic [LEN_W-1:0]              i_len,
    input  logic [tpwc_pkg::CODES_W-1:0]  i_codes,
    output logic                          o_ok
);
    import tpwc_pkg::*;

    t_trend           r_code;
    t_trend           n_code;
    logic [LEN_W-1:0] w_k;
    logic             w_active;
    t_trend           w_want;

    always_comb begin
        n_code = r_code;
        if (i_ctrl.clear) begin
            n_code = TREND_EQUAL;
        end else if (i_ctrl.shift) begin
            n_code = i_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= TREND_EQUAL;
        end else begin
            r_code <= n_code;
        end
    end

    // slot i lines up with pattern entry len-1-i
    assign w_active = i_len > LEN_W'(CELL_IDX);
    assign w_k      = i_len - LEN_W'(CELL_IDX) - LEN_W'(1);

    always_comb begin
        if (w_k < LEN_W'(CODE_ENTRIES)) begin
            w_want = i_codes[{w_k[3:0], 1'b0} +: 2];
        end else begin
            w_want = TREND_EQUAL;
        end
    end

    assign o_ok   = !w_active || (w_want == TREND_ANY) || (w_want == r_code);
    assign o_code = r_code;

endmodule

FILE: hdl/trend_pattern_window_counter_top.sv
// ----------------------------------------------------------------------------
// trend_pattern_window_counter_top
// Trend pattern matcher over a sliding window of signed samples.
// ----------------------------------------------------------------------------
// Takes one signed sample per beat, forms a rise/equal/fall code against the
// previous sample and shifts it into a row of PATTERN_MAX history cells. Each
// cell checks its own code against the pattern entry lined up with it; the
// window match and the saturating match count are formed in the next stage
// and land in an output register. When not stalled the rate is one sample
// per cycle; beats pass stage a, then the stage b output register. The match
// count is a single register updated once per result, fixing the pipeline at
// one result per clock. start_req clears history and count for its sample.
module trend_pattern_window_counter_top #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  tpwc_pkg::t_in_beat                i_in_data,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output tpwc_pkg::t_out_beat               o_out_data,
    input  logic                              i_out_stall,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tpwc_pkg::ADDR_W-1:0]       paddr,
    input  logic [tpwc_pkg::DATA_W-1:0]       pwdata,
    output logic [tpwc_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);
    import tpwc_pkg::*;

    localparam int SEEN_W = $clog2(PATTERN_MAX + 2);
    localparam int CW     = ((SEEN_W > LEN_REG_W) ? SEEN_W : LEN_REG_W) + 1;
    localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(PATTERN_MAX + 1);

    logic [LEN_REG_W-1:0] w_pattern_length;
    logic [CODES_W-1:0]   w_pattern_codes;
    logic [CW-1:0]        w_len_raw;
    logic [CW-1:0]        w_len;

    // stage a: history updated, result pending
    logic                  r_a_valid;
    logic                  r_a_start;
    logic [SEEN_W-1:0]     r_seen;
    logic [SAMPLE_W-1:0]   r_prev;
    // stage b: output register
    logic                  r_out_valid;
    t_out_beat             r_out_data;
    logic [COUNT_W-1:0]    r_count;

    logic                  w_accept;
    logic                  w_b_take;
    logic                  w_b_load;
    logic [SEEN_W-1:0]     w_seen_base;
    logic [SEEN_W-1:0]     n_seen;
    t_trend                w_new_code;
    t_cell_ctrl            w_ctrl;
    t_trend                w_link [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] w_ok;
    logic                  w_window_full;
    logic                  w_match;
    logic [COUNT_W-1:0]    w_count_base;
    logic [COUNT_W-1:0]    n_count;

    tpwc_regs u_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_pattern_length (w_pattern_length),
        .o_pattern_codes  (w_pattern_codes)
    );

    // effective length, clamped to 1..PATTERN_MAX
    assign w_len_raw = CW'(w_pattern_length);
    always_comb begin
        if (w_len_raw == '0) begin
            w_len = CW'(1);
        end else if (w_len_raw > CW'(PATTERN_MAX)) begin
            w_len = CW'(PATTERN_MAX);
        end else begin
            w_len = w_len_raw;
        end
    end

    // handshake
    assign w_b_take   = !r_out_valid || !i_out_stall;
    assign w_b_load   = r_a_valid && w_b_take;
    assign o_in_stall = r_a_valid && !w_b_take;
    assign w_accept   = i_in_valid && !o_in_stall;

    // stage a front: trend code and cell control
    assign w_seen_base = i_in_data.start_req ? '0 : r_seen;
    assign n_seen      = (w_seen_base == SEEN_MAX) ? w_seen_base : w_seen_base + SEEN_W'(1);

    always_comb begin
        if (i_in_data.sample > $signed(r_prev)) begin
            w_new_code = TREND_RISE;
        end else if (i_in_data.sample < $signed(r_prev)) begin
            w_new_code = TREND_FALL;
        end else begin
            w_new_code = TREND_EQUAL;
        end
    end

    assign w_ctrl.clear = w_accept && i_in_data.start_req;
    assign w_ctrl.shift = w_accept && (w_seen_base != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_start <= 1'b0;
            r_seen    <= '0;
            r_prev    <= '0;
        end else begin
            if (w_accept) begin
                r_a_valid <= 1'b1;
                r_a_start <= i_in_data.start_req;
                r_seen    <= n_seen;
                r_prev    <= i_in_data.sample;
            end else if (w_b_take) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    // history row, cell 0 holds the newest code
    for (genvar gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
        t_trend w_cell_in;
        if (gi == 0) begin : g_head
            assign w_cell_in = w_new_code;
        end else begin : g_body
            assign w_cell_in = w_link[gi-1];
        end
        tpwc_cell #(
            .CELL_IDX (gi),
            .LEN_W    (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_code  (w_cell_in),
            .o_code  (w_link[gi]),
            .i_len   (w_len),
            .i_codes (w_pattern_codes),
            .o_ok    (w_ok[gi])
        );
    end

    // stage b: match and saturating count
    assign w_window_full = CW'(r_seen) >= (w_len + CW'(1));
    assign w_match       = w_window_full && (&w_ok);
    assign w_count_base  = r_a_start ? '0 : r_count;
    assign n_count       = (w_match && (w_count_base != '1)) ? w_count_base + COUNT_W'(1)
                                                             : w_count_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_b_load) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_load) begin
            r_out_data.window_match <= w_match;
            r_out_data.match_count  <= n_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // checks
    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= SEEN_MAX)
        else $error("sample count beyond window depth");

    a_start_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.start_req) |=> (r_seen == SEEN_W'(1)))
        else $error("start beat did not restart the sample count");

    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_b_load && !r_a_start) |=> (r_count >= $past(r_count)))
        else $error("match count went down inside a sequence");

    a_match_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.window_match) |-> (o_out_data.match_count != '0))
        else $error("match reported with zero count");

endmodule
